// File: rtl/csan_pkg.sv
// Shared types, constants and character helpers for the chat text sanitizer.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package csan_pkg;

    localparam int MAX_CHARS_DEF = 255;
    localparam int QDEPTH        = 4;

    localparam logic [7:0] BYTE_MIRC  = 8'h03;
    localparam logic [7:0] BYTE_HEXC  = 8'h04;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_COMMA = 8'h2C;
    localparam logic [7:0] LEAD_2     = 8'hC0;
    localparam logic [7:0] LEAD_3     = 8'hE0;
    localparam logic [7:0] LEAD_4     = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LOW6_MASK  = 8'h3F;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_FG     = 3'd1,
        MODE_COMMA  = 3'd2,
        MODE_BG     = 3'd3,
        MODE_HEX    = 3'd4,
        MODE_UTF    = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] ch0;
        logic       v0;
        logic [7:0] ch1;
        logic       two;
        logic       last;
    } t_entry;

    function automatic logic is_dec(input logic [7:0] b);
        is_dec = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = is_dec(b) || ((b >= 8'h41) && (b <= 8'h46))
                 || ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic [7:0] fold(input logic [20:0] cp);
        unique case (cp)
            21'h000A0:          fold = 8'h20;
            21'h02018, 21'h02019: fold = 8'h27;
            21'h0201C, 21'h0201D: fold = 8'h22;
            21'h02013, 21'h02014: fold = 8'h2D;
            21'h02026:          fold = 8'h2E;
            default:            fold = 8'h3F;
        endcase
    endfunction

endpackage

// File: rtl/csan_front.sv
// Front end: accepts bytes, runs the color-code and UTF-8 parser, packs up to two
// results per request into one queue entry. Depends on csan_pkg.
module csan_front #(
    parameter int MAX_CHARS = csan_pkg::MAX_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_has_byte,
    input  logic             i_line_end,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output csan_pkg::t_entry o_entry
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_CHARS);

    csan_pkg::t_mode r_mode, n_mode;
    logic [2:0]      r_digits, n_digits;
    logic [20:0]     r_cp, n_cp;
    logic [1:0]      r_cont, n_cont;
    logic [CW-1:0]   r_count, n_count;

    logic [2:0]      req_v;
    logic [7:0]      req_c [3];
    logic            do_plain;
    logic [1:0]      extra;
    logic [1:0]      cont_nx;
    logic [20:0]     cp_nx;
    logic [CW-1:0]   cnt;
    logic [1:0]      ne;
    logic [7:0]      ch_a, ch_b;
    logic            accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_cp     = r_cp;
        n_cont   = r_cont;
        req_v    = 3'b000;
        req_c[0] = 8'h00;
        req_c[1] = 8'h00;
        req_c[2] = 8'h00;
        do_plain = 1'b0;
        extra    = 2'd0;
        cont_nx  = (r_cont != 2'd0) ? r_cont - 2'd1 : 2'd0;
        cp_nx    = {r_cp[14:0], i_in_byte[5:0]};

        if (i_has_byte) begin
            unique case (r_mode)
                csan_pkg::MODE_FG: begin
                    if (csan_pkg::is_dec(i_in_byte) && r_digits < 3'd2) begin
                        n_digits = r_digits + 3'd1;
                    end else if (i_in_byte == csan_pkg::BYTE_COMMA) begin
                        n_mode = csan_pkg::MODE_COMMA;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                csan_pkg::MODE_COMMA: begin
                    if (csan_pkg::is_dec(i_in_byte)) begin
                        n_mode   = csan_pkg::MODE_BG;
                        n_digits = 3'd1;
                    end else begin
                        req_v[0] = 1'b1;
                        req_c[0] = csan_pkg::BYTE_COMMA;
                        do_plain = 1'b1;
                    end
                end
                csan_pkg::MODE_BG: begin
                    if (csan_pkg::is_dec(i_in_byte) && r_digits < 3'd2) begin
                        n_digits = r_digits + 3'd1;
                        if (r_digits + 3'd1 >= 3'd2) begin
                            n_mode = csan_pkg::MODE_NORMAL;
                        end
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                csan_pkg::MODE_HEX: begin
                    if (csan_pkg::is_hex(i_in_byte) && r_digits < 3'd6) begin
                        n_digits = r_digits + 3'd1;
                        if (r_digits + 3'd1 >= 3'd6) begin
                            n_mode = csan_pkg::MODE_NORMAL;
                        end
                    end else begin
                        do_plain = 1'b1;
                    end
                end
                csan_pkg::MODE_UTF: begin
                    if ((i_in_byte & csan_pkg::CONT_MASK) == csan_pkg::CONT_TAG) begin
                        n_cp   = cp_nx;
                        n_cont = cont_nx;
                        if (cont_nx == 2'd0) begin
                            req_v[0] = 1'b1;
                            req_c[0] = csan_pkg::fold(cp_nx);
                            n_mode   = csan_pkg::MODE_NORMAL;
                        end
                    end else begin
                        req_v[0] = 1'b1;
                        req_c[0] = csan_pkg::fold(r_cp);
                        do_plain = 1'b1;
                    end
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase
        end

        if (do_plain) begin
            n_mode = csan_pkg::MODE_NORMAL;
            priority if (i_in_byte == csan_pkg::BYTE_MIRC) begin
                n_mode   = csan_pkg::MODE_FG;
                n_digits = 3'd0;
            end else if (i_in_byte == csan_pkg::BYTE_HEXC) begin
                n_mode   = csan_pkg::MODE_HEX;
                n_digits = 3'd0;
            end else if (i_in_byte < csan_pkg::BYTE_SPACE
                         || i_in_byte == csan_pkg::BYTE_DEL) begin
                n_mode = csan_pkg::MODE_NORMAL;
            end else if (i_in_byte < csan_pkg::LEAD_2) begin
                req_v[1] = 1'b1;
                req_c[1] = i_in_byte;
            end else begin
                extra  = (i_in_byte < csan_pkg::LEAD_3) ? 2'd1 :
                         (i_in_byte < csan_pkg::LEAD_4) ? 2'd2 : 2'd3;
                n_cp   = {13'd0, i_in_byte & (csan_pkg::LOW6_MASK >> extra)};
                n_cont = extra;
                n_mode = csan_pkg::MODE_UTF;
            end
        end

        if (i_line_end) begin
            if (n_mode == csan_pkg::MODE_COMMA) begin
                req_v[2] = 1'b1;
                req_c[2] = csan_pkg::BYTE_COMMA;
            end else if (n_mode == csan_pkg::MODE_UTF) begin
                req_v[2] = 1'b1;
                req_c[2] = csan_pkg::fold(n_cp);
            end
            n_mode   = csan_pkg::MODE_NORMAL;
            n_digits = 3'd0;
            n_cp     = 21'd0;
            n_cont   = 2'd0;
        end
    end

    always_comb begin
        cnt  = r_count;
        ne   = 2'd0;
        ch_a = 8'h00;
        ch_b = 8'h00;
        for (int k = 0; k < 3; k++) begin
            if (req_v[k] && cnt < LIMIT && ne < 2'd2) begin
                if (ne == 2'd0) begin
                    ch_a = req_c[k];
                end else begin
                    ch_b = req_c[k];
                end
                ne  = ne + 2'd1;
                cnt = cnt + CW'(1);
            end
        end
        n_count      = i_line_end ? '0 : cnt;
        o_push       = accept && (ne != 2'd0 || i_line_end);
        o_entry.ch0  = ch_a;
        o_entry.v0   = (ne != 2'd0);
        o_entry.ch1  = ch_b;
        o_entry.two  = (ne == 2'd2);
        o_entry.last = i_line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= csan_pkg::MODE_NORMAL;
            r_digits <= 3'd0;
            r_cp     <= 21'd0;
            r_cont   <= 2'd0;
            r_count  <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_digits <= n_digits;
            r_cp     <= n_cp;
            r_cont   <= n_cont;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LIMIT)
        else $error("character count past limit");
    a_utf_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == csan_pkg::MODE_UTF) |-> (r_cont != 2'd0))
        else $error("utf mode with no continuation pending");
`endif

endmodule

// File: rtl/csan_queue.sv
// Short request queue between the parser front end and the output back end.
// Depends on csan_pkg for the entry type and depth.
module csan_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  csan_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output csan_pkg::t_entry o_head
);

    localparam int AW = $clog2(csan_pkg::QDEPTH);
    localparam int CW = $clog2(csan_pkg::QDEPTH + 1);

    csan_pkg::t_entry r_mem [csan_pkg::QDEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(csan_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(csan_pkg::QDEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(csan_pkg::QDEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: rtl/csan_back.sv
// Back end: unpacks queue entries into single results and holds them in the
// output register until taken. Depends on csan_pkg.
module csan_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  csan_pkg::t_entry i_head,
    input  logic             i_ready,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_out_char,
    output logic             o_char_valid,
    output logic             o_line_end_res
);

    logic       r_valid, r_half;
    logic [7:0] r_char;
    logic       r_cvalid, r_end;
    logic       load;

    assign load  = (!r_valid || i_ready) && !i_empty;
    assign o_pop = load && (r_half || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char   <= r_half ? i_head.ch1 : i_head.ch0;
            r_cvalid <= r_half ? 1'b1 : i_head.v0;
            r_end    <= i_head.last && (r_half || !i_head.two);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= !r_half && i_head.two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_out_char     = r_char;
    assign o_char_valid   = r_cvalid;
    assign o_line_end_res = r_end;

`ifndef ASSERT_OFF
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_cvalid) |-> r_end)
        else $error("empty result that does not end the line");
`endif

endmodule

// File: rtl/chat_text_sanitizer.sv
// Top level of the chat text sanitizer: parser front end, request queue, output back end.
// Depends on csan_pkg, csan_front, csan_queue and csan_back.
//
//   channel  valid    ready    payload
//   input    i_valid  o_ready  i_in_byte, i_has_byte, i_line_end
//   output   o_valid  i_ready  o_out_char, o_char_valid, o_line_end_res
//
// One input request per cycle while the queue has room; each yields zero to two results.
// Results leave the output register one per cycle while i_ready is high, each request's
// going through the queue and then that register; two-result requests are unpacked one at
// a time, absorbed by the four-entry queue. Synchronous active-low reset clears parser state,
// queue and output. Output stalls fill the queue; input is held off only when it is full.
module chat_text_sanitizer #(
    parameter int MAX_CHARS = csan_pkg::MAX_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_has_byte,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_line_end_res
);

    csan_pkg::t_entry push_entry, head_entry;
    logic             push, pop, q_full, q_empty;

    csan_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_has_byte (i_has_byte),
        .i_line_end (i_line_end),
        .i_q_full   (q_full),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    csan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    csan_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_entry),
        .i_ready        (i_ready),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_line_end_res (o_line_end_res)
    );

endmodule

// File: sim/chat_text_sanitizer_chk.sv
// Checker for the chat text sanitizer: watches both request channels, predicts the cleaned
// characters of every accepted input request and compares them with the results in order.
// Depends on csan_pkg for the parse modes and byte constants.
`timescale 1ns / 1ps

module chat_text_sanitizer_chk #(
    parameter int MAX_CHARS = csan_pkg::MAX_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_has_byte,
    input  logic       i_line_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_char_valid,
    input  logic       i_line_end_res,
    output int         o_errors,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       last;
    } t_result;

    t_result         exp_cells[$];
    t_result         want;
    csan_pkg::t_mode mode;
    logic [2:0]      n_digits;
    logic [20:0]     cp_acc;
    logic [1:0]      cont_left;
    int              line_chars;
    int              errors = 0;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_hexdig(input logic [7:0] b);
        return is_digit(b) || ((b >= "A") && (b <= "F")) || ((b >= "a") && (b <= "f"));
    endfunction

    function automatic logic [7:0] fold_cp(input logic [20:0] cp);
        case (cp)
            21'h000A0:            return 8'h20;
            21'h02018, 21'h02019: return 8'h27;
            21'h0201C, 21'h0201D: return 8'h22;
            21'h02013, 21'h02014: return 8'h2D;
            21'h02026:            return 8'h2E;
            default:              return 8'h3F;
        endcase
    endfunction

    function automatic void clear_line();
        mode       = csan_pkg::MODE_NORMAL;
        n_digits   = '0;
        cp_acc     = '0;
        cont_left  = '0;
        line_chars = 0;
    endfunction

    function automatic int push_char(input logic [7:0] c, input int n);
        t_result res;
        if (line_chars >= MAX_CHARS || n >= 2) return n;
        res.ch   = c;
        res.cv   = 1'b1;
        res.last = 1'b0;
        exp_cells.push_back(res);
        line_chars++;
        return n + 1;
    endfunction

    function automatic int take_text(input logic [7:0] b, input int n);
        logic [1:0] extra;
        mode = csan_pkg::MODE_NORMAL;
        if (b == csan_pkg::BYTE_MIRC) begin
            mode     = csan_pkg::MODE_FG;
            n_digits = '0;
        end else if (b == csan_pkg::BYTE_HEXC) begin
            mode     = csan_pkg::MODE_HEX;
            n_digits = '0;
        end else if (b < csan_pkg::BYTE_SPACE || b == csan_pkg::BYTE_DEL) begin
            return n;
        end else if (b < csan_pkg::LEAD_2) begin
            return push_char(b, n);
        end else begin
            extra     = (b < csan_pkg::LEAD_3) ? 2'd1 : (b < csan_pkg::LEAD_4) ? 2'd2 : 2'd3;
            cp_acc    = 21'(b & (csan_pkg::LOW6_MASK >> extra));
            cont_left = extra;
            mode      = csan_pkg::MODE_UTF;
        end
        return n;
    endfunction

    function automatic void sanitize_request(input logic [7:0] b, input logic hb,
                                             input logic le);
        int      n;
        t_result res;
        n = 0;
        if (hb) begin
            case (mode)
                csan_pkg::MODE_FG: begin
                    if (is_digit(b) && n_digits < 2) n_digits++;
                    else if (b == csan_pkg::BYTE_COMMA) mode = csan_pkg::MODE_COMMA;
                    else n = take_text(b, n);
                end
                csan_pkg::MODE_COMMA: begin
                    if (is_digit(b)) begin
                        mode     = csan_pkg::MODE_BG;
                        n_digits = 3'd1;
                    end else begin
                        n = push_char(csan_pkg::BYTE_COMMA, n);
                        n = take_text(b, n);
                    end
                end
                csan_pkg::MODE_BG: begin
                    if (is_digit(b) && n_digits < 2) begin
                        n_digits++;
                        if (n_digits >= 2) mode = csan_pkg::MODE_NORMAL;
                    end else begin
                        n = take_text(b, n);
                    end
                end
                csan_pkg::MODE_HEX: begin
                    if (is_hexdig(b) && n_digits < 6) begin
                        n_digits++;
                        if (n_digits >= 6) mode = csan_pkg::MODE_NORMAL;
                    end else begin
                        n = take_text(b, n);
                    end
                end
                csan_pkg::MODE_UTF: begin
                    if ((b & csan_pkg::CONT_MASK) == csan_pkg::CONT_TAG) begin
                        cp_acc = {cp_acc[14:0], b[5:0]};
                        if (cont_left != 0) cont_left--;
                        if (cont_left == 0) begin
                            n    = push_char(fold_cp(cp_acc), n);
                            mode = csan_pkg::MODE_NORMAL;
                        end
                    end else begin
                        n = push_char(fold_cp(cp_acc), n);
                        n = take_text(b, n);
                    end
                end
                default: n = take_text(b, n);
            endcase
        end
        if (le) begin
            if (mode == csan_pkg::MODE_COMMA) n = push_char(csan_pkg::BYTE_COMMA, n);
            else if (mode == csan_pkg::MODE_UTF) n = push_char(fold_cp(cp_acc), n);
            clear_line();
            if (n == 0) begin
                res.ch = 8'h00;
                res.cv = 1'b0;
            end else begin
                res = exp_cells.pop_back();
            end
            res.last = 1'b1;
            exp_cells.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            exp_cells.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (exp_cells.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: char %02h valid %b end %b", $time,
                             i_out_char, i_char_valid, i_line_end_res);
                end else begin
                    want = exp_cells.pop_front();
                    if (i_out_char !== want.ch) begin
                        errors++;
                        $display("%0t: out_char expected %02h, got %02h", $time,
                                 want.ch, i_out_char);
                    end
                    if (i_char_valid !== want.cv) begin
                        errors++;
                        $display("%0t: char_valid expected %b, got %b", $time,
                                 want.cv, i_char_valid);
                    end
                    if (i_line_end_res !== want.last) begin
                        errors++;
                        $display("%0t: line_end_res expected %b, got %b", $time,
                                 want.last, i_line_end_res);
                    end
                end
            end
            if (i_in_valid && i_in_ready) sanitize_request(i_in_byte, i_has_byte, i_line_end);
        end
        o_errors  <= errors;
        o_pending <= exp_cells.size();
    end

endmodule

// File: sim/chat_text_sanitizer_tb.sv
// Testbench top for the chat text sanitizer: clock, reset, request stimulus and verdict.
// Depends on csan_pkg, chat_text_sanitizer and chat_text_sanitizer_chk.
`timescale 1ns / 1ps

module chat_text_sanitizer_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_has_byte;
    logic       i_line_end;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_line_end_res;

    int errors;
    int pending;
    int cycles;
    int send_idle;
    int recv_stall;
    bit hold_phase;
    int sent_items;

    chat_text_sanitizer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_byte      (i_in_byte),
        .i_has_byte     (i_has_byte),
        .i_line_end     (i_line_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_char     (o_out_char),
        .o_char_valid   (o_char_valid),
        .o_line_end_res (o_line_end_res)
    );

    chat_text_sanitizer_chk chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_in_byte      (i_in_byte),
        .i_has_byte     (i_has_byte),
        .i_line_end     (i_line_end),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_out_char     (o_out_char),
        .i_char_valid   (o_char_valid),
        .i_line_end_res (o_line_end_res),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_phase && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    task automatic send_req(input logic [7:0] b, input logic hb, input logic le);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_byte  <= b;
        i_has_byte <= hb;
        i_line_end <= le;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (hb || le) sent_items++;
    endtask

    function automatic logic [7:0] hex_char();
        int k;
        k = $urandom_range(21);
        if (k < 10) return 8'("0" + k);
        if (k < 16) return 8'("A" + k - 10);
        return 8'("a" + k - 16);
    endfunction

    function automatic logic [7:0] punct_tail(input int k);
        case (k)
            0:       return 8'h93;
            1:       return 8'h94;
            2:       return 8'h98;
            3:       return 8'h99;
            4:       return 8'h9C;
            5:       return 8'h9D;
            default: return 8'hA6;
        endcase
    endfunction

    task automatic send_utf(input bit cut_short);
        logic [7:0] lead;
        int         len;
        int         k;
        if (!cut_short && $urandom_range(99) < 40) begin
            k = $urandom_range(7);
            if (k == 0) begin
                send_req(8'hC2, 1'b1, 1'b0);
                send_req(8'hA0, 1'b1, 1'b0);
            end else begin
                send_req(8'hE2, 1'b1, 1'b0);
                send_req(8'h80, 1'b1, 1'b0);
                send_req(punct_tail(k - 1), 1'b1, 1'b0);
            end
        end else begin
            lead = 8'($urandom_range(8'hFF, 8'hC0));
            len  = (lead < csan_pkg::LEAD_3) ? 1 : (lead < csan_pkg::LEAD_4) ? 2 : 3;
            if (cut_short) len = $urandom_range(len - 1);
            send_req(lead, 1'b1, 1'b0);
            repeat (len) send_req(8'($urandom_range(8'hBF, 8'h80)), 1'b1, 1'b0);
        end
    endtask

    task automatic send_token();
        int kind;
        kind = $urandom_range(99);
        if (kind < 30) begin
            repeat ($urandom_range(5, 1)) send_req(8'($urandom_range(8'h7E, 8'h20)), 1'b1, 1'b0);
        end else if (kind < 45) begin
            send_req(csan_pkg::BYTE_MIRC, 1'b1, 1'b0);
            repeat ($urandom_range(3)) send_req(8'("0" + $urandom_range(9)), 1'b1, 1'b0);
            if ($urandom_range(1)) begin
                send_req(csan_pkg::BYTE_COMMA, 1'b1, 1'b0);
                repeat ($urandom_range(3)) send_req(8'("0" + $urandom_range(9)), 1'b1, 1'b0);
            end
        end else if (kind < 55) begin
            send_req(csan_pkg::BYTE_HEXC, 1'b1, 1'b0);
            repeat ($urandom_range(7)) send_req(hex_char(), 1'b1, 1'b0);
        end else if (kind < 75) begin
            send_utf(1'b0);
        end else if (kind < 83) begin
            send_utf(1'b1);
        end else if (kind < 90) begin
            if ($urandom_range(7) == 0) send_req(csan_pkg::BYTE_DEL, 1'b1, 1'b0);
            else send_req(8'($urandom_range(8'h1F)), 1'b1, 1'b0);
        end else if (kind < 95) begin
            send_req(8'($urandom_range(255)), 1'b1, 1'b0);
        end else begin
            send_req(8'($urandom_range(255)), 1'b0, 1'b0);
        end
    endtask

    task automatic send_line(input int max_tokens);
        repeat ($urandom_range(max_tokens, 1)) send_token();
        send_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
        int target;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        target     = sent_items + n_items;
        while (sent_items < target) send_line(12);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_byte  = 8'h00;
        i_has_byte = 1'b0;
        i_line_end = 1'b0;
        i_ready    = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        hold_phase = 1'b0;
        sent_items = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_req(8'hFF, 1'b0, 1'b1);
        send_req(8'hA5, 1'b0, 1'b0);
        send_req("A", 1'b1, 1'b0);
        send_req(8'h00, 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_DEL, 1'b1, 1'b0);
        send_req(8'hBF, 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_MIRC, 1'b1, 1'b0);
        send_req("1", 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_COMMA, 1'b1, 1'b0);
        send_req("2", 1'b1, 1'b0);
        send_req("x", 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_MIRC, 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_COMMA, 1'b1, 1'b0);
        send_req("a", 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_HEXC, 1'b1, 1'b0);
        send_req("F", 1'b1, 1'b0);
        send_req("f", 1'b1, 1'b0);
        send_req(8'hE2, 1'b1, 1'b0);
        send_req(8'h80, 1'b1, 1'b0);
        send_req(8'h98, 1'b1, 1'b0);
        send_req(8'hFF, 1'b1, 1'b0);
        send_req("Z", 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_MIRC, 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_COMMA, 1'b1, 1'b1);

        // overflow the per-line character limit while the receiver holds off
        hold_phase = 1'b1;
        repeat (262) send_req(8'($urandom_range(8'h7E, 8'h20)), 1'b1, 1'b0);
        send_utf(1'b0);
        send_req(csan_pkg::BYTE_MIRC, 1'b1, 1'b0);
        send_req(csan_pkg::BYTE_COMMA, 1'b1, 1'b1);

        run_phase(0, 0, 60);
        run_phase(75, 0, 100);
        run_phase(0, 75, 100);
        run_phase(38, 38, 100);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
